[rtl/vwes_pkg.sv]
// Shared types, sizes and codes for the vertex weld scan block.
package vwes_pkg;

  // Store depths.
  localparam int MAX_UNIQUE         = 4096;
  localparam int MAX_INPUT_VERTICES = 4096;

  localparam int UNIQUE_IDX_W = $clog2(MAX_UNIQUE);
  localparam int UNIQUE_CNT_W = $clog2(MAX_UNIQUE + 1);
  localparam int MAP_IDX_W    = $clog2(MAX_INPUT_VERTICES);
  localparam int MAP_CNT_W    = $clog2(MAX_INPUT_VERTICES + 1);

  // Field widths fixed by the stream format.
  localparam int COORD_W     = 32;
  localparam int TOL_W       = 31;
  localparam int OLD_INDEX_W = 12;
  localparam int NEW_INDEX_W = 12;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;

  // Stream widths.
  localparam int VERTEX_W       = 8 * COORD_W;
  localparam int S_TDATA_W      = ((VERTEX_W + OLD_INDEX_W + 7) / 8) * 8;
  localparam int M_TDATA_W      = ((NEW_INDEX_W + 7) / 8) * 8;
  localparam int M_TUSER_W      = 1 + STATUS_W;
  localparam int CFG_IDX_W      = 3;
  localparam int MAP_ENTRY_W    = UNIQUE_IDX_W + 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_REMAP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NRM_TOL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_TOL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NRM_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_EN  = 3'd4;

  // One vertex; pos_x sits in the lowest bits, as on the input stream.
  typedef struct packed {
    logic signed [COORD_W-1:0] tex_v;
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] normal_z;
    logic signed [COORD_W-1:0] normal_y;
    logic signed [COORD_W-1:0] normal_x;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_x;
  } vertex_t;

  // Matching controls handed to the compare unit.
  typedef struct packed {
    logic [TOL_W-1:0] pos_tol;
    logic [TOL_W-1:0] nrm_tol;
    logic [TOL_W-1:0] tex_tol;
    logic             nrm_en;
    logic             tex_en;
  } match_cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_MAP_RD,
    S_MAP_CHK,
    S_RESP
  } state_e;

endpackage

[rtl/vwes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module vwes_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/vwes_match.sv]
// Tolerance compare unit: one incoming vertex against one stored vertex per cycle.
module vwes_match (
  input  vwes_pkg::vertex_t    probe_i,
  input  vwes_pkg::vertex_t    stored_i,
  input  vwes_pkg::match_cfg_t cfg_i,
  output logic                 hit_o
);

  // Exact |a - b| <= tol, taken one bit wider so it never wraps.
  function automatic logic near(input logic signed [vwes_pkg::COORD_W-1:0] a,
                                input logic signed [vwes_pkg::COORD_W-1:0] b,
                                input logic [vwes_pkg::TOL_W-1:0]          tol);
    logic signed [vwes_pkg::COORD_W:0] diff;
    logic        [vwes_pkg::COORD_W:0] mag;
    diff = $signed({a[vwes_pkg::COORD_W-1], a}) - $signed({b[vwes_pkg::COORD_W-1], b});
    mag  = diff[vwes_pkg::COORD_W] ? $unsigned(-diff) : $unsigned(diff);
    return mag <= {{(vwes_pkg::COORD_W + 1 - vwes_pkg::TOL_W){1'b0}}, tol};
  endfunction

  logic pos_ok;
  logic nrm_ok;
  logic tex_ok;

  assign pos_ok = near(probe_i.pos_x, stored_i.pos_x, cfg_i.pos_tol)
                & near(probe_i.pos_y, stored_i.pos_y, cfg_i.pos_tol)
                & near(probe_i.pos_z, stored_i.pos_z, cfg_i.pos_tol);

  assign nrm_ok = near(probe_i.normal_x, stored_i.normal_x, cfg_i.nrm_tol)
                & near(probe_i.normal_y, stored_i.normal_y, cfg_i.nrm_tol)
                & near(probe_i.normal_z, stored_i.normal_z, cfg_i.nrm_tol);

  assign tex_ok = near(probe_i.tex_u, stored_i.tex_u, cfg_i.tex_tol)
                & near(probe_i.tex_v, stored_i.tex_v, cfg_i.tex_tol);

  assign hit_o = pos_ok & (~cfg_i.nrm_en | nrm_ok) & (~cfg_i.tex_en | tex_ok);

endmodule

[rtl/vertex_weld_epsilon_scan_core.sv]
// Add vertex scans up to N stored vertices, one read per cycle into the shared compare
// unit, then commits; remap reads the map; clear, unknown op, early reject just respond.
// Throughput: one word in flight; the next input word is taken once the result is queued in
// the output register, even while that register still waits for m_axis_tready.
// Reset: clears both counts, the configuration and the handshake state; vertex and map RAMs
// are not cleared, since only entries below the counts are ever read.
module vertex_weld_epsilon_scan_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v,
  // old_index, 4 zero bits.
  input  logic [vwes_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // tuser: operation.
  input  logic [vwes_pkg::OP_W-1:0]           s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low bit up: new_index, 4 zero bits.
  output logic [vwes_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  // tuser, low bit up: is_new, status.
  output logic [vwes_pkg::M_TUSER_W-1:0]      m_axis_tuser,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [vwes_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [vwes_pkg::TOL_W-1:0]          cfg_data_i
);

  vwes_pkg::state_e state_q, state_d;

  // Item registers.
  vwes_pkg::vertex_t                vtx_q, vtx_d;
  logic [vwes_pkg::OLD_INDEX_W-1:0] old_idx_q, old_idx_d;

  // Store fill counts.
  logic [vwes_pkg::UNIQUE_CNT_W-1:0] uc_q, uc_d;
  logic [vwes_pkg::MAP_CNT_W-1:0]    mc_q, mc_d;

  // Scan pipeline: read address, then the compare slot in the cycle after.
  logic [vwes_pkg::UNIQUE_CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic                              cmp_vld_q, cmp_vld_d;
  logic [vwes_pkg::UNIQUE_IDX_W-1:0] cmp_idx_q, cmp_idx_d;

  // Pending result.
  logic [vwes_pkg::UNIQUE_IDX_W-1:0] res_idx_q, res_idx_d;
  logic                              res_new_q, res_new_d;
  logic [vwes_pkg::STATUS_W-1:0]     res_status_q, res_status_d;
  logic                              res_map_vld_q, res_map_vld_d;

  // Output register.
  logic                              m_valid_q, m_valid_d;
  logic [vwes_pkg::UNIQUE_IDX_W-1:0] m_idx_q, m_idx_d;
  logic                              m_new_q, m_new_d;
  logic [vwes_pkg::STATUS_W-1:0]     m_status_q, m_status_d;

  vwes_pkg::match_cfg_t cfg_q, cfg_d;

  // RAM ports and compare unit.
  logic                                vtx_we;
  vwes_pkg::vertex_t                   vtx_rdata;
  logic                                map_we;
  logic [vwes_pkg::MAP_ENTRY_W-1:0]    map_rdata;
  logic                                hit;

  logic in_accept;
  logic out_free;
  logic scan_hit;
  logic scan_more;
  logic uc_full;
  logic mc_full;
  logic old_unmapped;

  assign s_axis_tready = (state_q == vwes_pkg::S_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;

  assign scan_hit     = cmp_vld_q & hit;
  assign scan_more    = rd_idx_q < uc_q;
  assign uc_full      = uc_q == vwes_pkg::UNIQUE_CNT_W'(vwes_pkg::MAX_UNIQUE);
  assign mc_full      = mc_q == vwes_pkg::MAP_CNT_W'(vwes_pkg::MAX_INPUT_VERTICES);
  assign old_unmapped = vwes_pkg::MAP_CNT_W'(s_axis_tdata[vwes_pkg::VERTEX_W +:
                                                          vwes_pkg::OLD_INDEX_W]) >= mc_q;

  // Vertex store: one entry per unique vertex, read once per scan cycle.
  vwes_ram #(
    .Width ($bits(vwes_pkg::vertex_t)),
    .Depth (vwes_pkg::MAX_UNIQUE)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (vtx_we),
    .waddr_i (uc_q[vwes_pkg::UNIQUE_IDX_W-1:0]),
    .wdata_i (vtx_q),
    .raddr_i (rd_idx_q[vwes_pkg::UNIQUE_IDX_W-1:0]),
    .rdata_o (vtx_rdata)
  );

  // Old-to-new map: {valid, unique index} per input vertex.
  vwes_ram #(
    .Width (vwes_pkg::MAP_ENTRY_W),
    .Depth (vwes_pkg::MAX_INPUT_VERTICES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (mc_q[vwes_pkg::MAP_IDX_W-1:0]),
    .wdata_i ({res_map_vld_q, res_idx_q}),
    .raddr_i (vwes_pkg::MAP_IDX_W'(old_idx_q)),
    .rdata_o (map_rdata)
  );

  vwes_match u_match (
    .probe_i  (vtx_q),
    .stored_i (vtx_rdata),
    .cfg_i    (cfg_q),
    .hit_o    (hit)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vwes_pkg::S_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser == vwes_pkg::OP_ADD && !mc_full) begin
            state_d = vwes_pkg::S_SCAN;
          end else if (s_axis_tuser == vwes_pkg::OP_REMAP && !old_unmapped) begin
            state_d = vwes_pkg::S_MAP_RD;
          end else begin
            state_d = vwes_pkg::S_RESP;
          end
        end
      end
      vwes_pkg::S_SCAN: begin
        if (scan_hit || !scan_more) begin
          state_d = vwes_pkg::S_COMMIT;
        end
      end
      vwes_pkg::S_COMMIT:  state_d = vwes_pkg::S_RESP;
      vwes_pkg::S_MAP_RD:  state_d = vwes_pkg::S_MAP_CHK;
      vwes_pkg::S_MAP_CHK: state_d = vwes_pkg::S_RESP;
      vwes_pkg::S_RESP: begin
        if (out_free) begin
          state_d = vwes_pkg::S_IDLE;
        end
      end
      default: state_d = vwes_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs per state.
  always_comb begin
    vtx_d         = vtx_q;
    old_idx_d     = old_idx_q;
    uc_d          = uc_q;
    mc_d          = mc_q;
    rd_idx_d      = rd_idx_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    res_idx_d     = res_idx_q;
    res_new_d     = res_new_q;
    res_status_d  = res_status_q;
    res_map_vld_d = res_map_vld_q;
    m_valid_d     = m_valid_q & ~m_axis_tready;
    m_idx_d       = m_idx_q;
    m_new_d       = m_new_q;
    m_status_d    = m_status_q;
    vtx_we        = 1'b0;
    map_we        = 1'b0;

    unique case (state_q)
      vwes_pkg::S_IDLE: begin
        if (in_accept) begin
          vtx_d        = vwes_pkg::vertex_t'(s_axis_tdata[vwes_pkg::VERTEX_W-1:0]);
          old_idx_d    = s_axis_tdata[vwes_pkg::VERTEX_W +: vwes_pkg::OLD_INDEX_W];
          rd_idx_d     = '0;
          res_idx_d    = '0;
          res_new_d    = 1'b0;
          res_status_d = vwes_pkg::ST_OK;
          case (s_axis_tuser)
            vwes_pkg::OP_ADD: begin
              if (mc_full) begin
                res_status_d = vwes_pkg::ST_FULL;
              end
            end
            vwes_pkg::OP_REMAP: begin
              if (old_unmapped) begin
                res_status_d = vwes_pkg::ST_UNMAPPED;
              end
            end
            vwes_pkg::OP_CLEAR: begin
              uc_d = '0;
              mc_d = '0;
            end
            default: ;
          endcase
        end
      end
      vwes_pkg::S_SCAN: begin
        if (scan_hit) begin
          // First match wins; any read still in flight is dropped.
          res_idx_d     = cmp_idx_q;
          res_map_vld_d = 1'b1;
        end else if (scan_more) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[vwes_pkg::UNIQUE_IDX_W-1:0];
        end else if (uc_full) begin
          res_status_d  = vwes_pkg::ST_FULL;
          res_map_vld_d = 1'b0;
        end else begin
          res_idx_d     = uc_q[vwes_pkg::UNIQUE_IDX_W-1:0];
          res_new_d     = 1'b1;
          res_map_vld_d = 1'b1;
        end
      end
      vwes_pkg::S_COMMIT: begin
        // Record the map entry; append the vertex only when it is new.
        map_we = 1'b1;
        mc_d   = mc_q + 1'b1;
        vtx_we = res_new_q;
        if (res_new_q) begin
          uc_d = uc_q + 1'b1;
        end
      end
      vwes_pkg::S_MAP_RD: ;
      vwes_pkg::S_MAP_CHK: begin
        if (map_rdata[vwes_pkg::UNIQUE_IDX_W]) begin
          res_idx_d = map_rdata[vwes_pkg::UNIQUE_IDX_W-1:0];
        end else begin
          res_status_d = vwes_pkg::ST_UNMAPPED;
        end
      end
      vwes_pkg::S_RESP: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_idx_d    = res_idx_q;
          m_new_d    = res_new_q;
          m_status_d = res_status_q;
        end
      end
      default: ;
    endcase
  end

  // Configuration writes; indexes beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vwes_pkg::CFG_POS_TOL: cfg_d.pos_tol = cfg_data_i;
        vwes_pkg::CFG_NRM_TOL: cfg_d.nrm_tol = cfg_data_i;
        vwes_pkg::CFG_TEX_TOL: cfg_d.tex_tol = cfg_data_i;
        vwes_pkg::CFG_NRM_EN:  cfg_d.nrm_en  = cfg_data_i[0];
        vwes_pkg::CFG_TEX_EN:  cfg_d.tex_en  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vwes_pkg::S_IDLE;
      uc_q      <= '0;
      mc_q      <= '0;
      cmp_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
      cfg_q     <= '0;
    end else begin
      state_q   <= state_d;
      uc_q      <= uc_d;
      mc_q      <= mc_d;
      cmp_vld_q <= cmp_vld_d;
      m_valid_q <= m_valid_d;
      cfg_q     <= cfg_d;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    vtx_q         <= vtx_d;
    old_idx_q     <= old_idx_d;
    rd_idx_q      <= rd_idx_d;
    cmp_idx_q     <= cmp_idx_d;
    res_idx_q     <= res_idx_d;
    res_new_q     <= res_new_d;
    res_status_q  <= res_status_d;
    res_map_vld_q <= res_map_vld_d;
    m_idx_q       <= m_idx_d;
    m_new_q       <= m_new_d;
    m_status_q    <= m_status_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(vwes_pkg::M_TDATA_W - vwes_pkg::NEW_INDEX_W){1'b0}},
                          vwes_pkg::NEW_INDEX_W'(m_idx_q)};
  assign m_axis_tuser  = {m_status_q, m_new_q};

endmodule
